[rtl/slmr_pkg.sv]
// shared types and constants for the sorted link merge reducer
`timescale 1ns / 1ps
package slmr_pkg;
  localparam int NUM_STREAMS = 16;
  localparam int STREAM_W = $clog2(NUM_STREAMS);
  localparam int NODE_W = 32;
  localparam int CNT_W = 16;
  localparam int GAP_W = 32;
  localparam int RNG_W = 31;
  localparam int TOT_W = 20;
  localparam int SUM_W = 53;
  localparam int DIV_STEPS = SUM_W;
  localparam int DCNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] KIND_REQ  = 2'd0;
  localparam logic [1:0] KIND_EDGE = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [2:0] REG_MIN_LINK_COUNT = 3'd0;

  typedef struct packed {
    logic accept;
    logic min_step;
    logic acc_step;
    logic div_start;
    logic div_step;
    logic idx_step;
    logic load_edge;
    logic load_req;
    logic load_done;
    logic set_await;
  } slmr_cmd_t;

  typedef struct packed {
    logic trigger;
    logic none_live;
    logic idx_last;
    logic pass;
    logic div_done;
    logic emit_ok;
    logic cur_consumed;
    logic out_free;
  } slmr_sts_t;
endpackage

[rtl/slmr_ctrl.sv]
// controller state machine: sequences scan, accumulate, divide and emit
`timescale 1ns / 1ps
module slmr_ctrl import slmr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  slmr_sts_t  sts,
  output slmr_cmd_t  cmd
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DONE = 3'd1;
  localparam logic [2:0] ST_MIN  = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_EDGE = 3'd6;
  localparam logic [2:0] ST_REQ  = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (sts.trigger) begin
            state_nxt = sts.none_live ? ST_DONE : ST_MIN;
          end
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_done = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_MIN: begin
        cmd.min_step = 1'b1;
        cmd.idx_step = 1'b1;
        if (sts.idx_last) state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_step = 1'b1;
        cmd.idx_step = 1'b1;
        if (sts.idx_last) state_nxt = ST_CHK;
      end
      ST_CHK: begin
        cmd.set_await = 1'b1;
        if (sts.pass) begin
          cmd.div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_REQ;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_EDGE;
      end
      ST_EDGE: begin
        if (!sts.emit_ok) begin
          state_nxt = ST_REQ;
        end else if (sts.out_free) begin
          cmd.load_edge = 1'b1;
          state_nxt = ST_REQ;
        end
      end
      ST_REQ: begin
        if (!sts.cur_consumed || sts.out_free) begin
          cmd.load_req = sts.cur_consumed;
          cmd.idx_step = 1'b1;
          if (sts.idx_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

[rtl/slmr_dp.sv]
// datapath: stream heads, masks, min scan, accumulators, dividers, result register
`timescale 1ns / 1ps
module slmr_dp import slmr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  slmr_cmd_t           cmd,
  output slmr_sts_t           sts,
  input  logic [STREAM_W-1:0] in_stream,
  input  logic                in_ended,
  input  logic [NODE_W-1:0]   in_from,
  input  logic [NODE_W-1:0]   in_to,
  input  logic [CNT_W-1:0]    in_count,
  input  logic [GAP_W-1:0]    in_gap,
  input  logic [RNG_W-1:0]    in_range,
  input  logic [TOT_W-1:0]    min_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic                out_last,
  output logic [STREAM_W-1:0] out_req,
  output logic [NODE_W-1:0]   out_from,
  output logic [NODE_W-1:0]   out_to,
  output logic [TOT_W-1:0]    out_total,
  output logic [GAP_W-1:0]    out_gap,
  output logic [RNG_W-1:0]    out_range
);
  logic [NODE_W-1:0] head_from_r [NUM_STREAMS];
  logic [NODE_W-1:0] head_to_r [NUM_STREAMS];
  logic [CNT_W-1:0]  head_cnt_r [NUM_STREAMS];
  logic [GAP_W-1:0]  head_gap_r [NUM_STREAMS];
  logic [RNG_W-1:0]  head_rng_r [NUM_STREAMS];

  logic [NUM_STREAMS-1:0] live_r, await_r, cons_r;
  logic                   finished_r;
  logic [STREAM_W-1:0]    idx_r;
  logic                   have_r;
  logic [NODE_W-1:0]      min_from_r, min_to_r;
  logic [TOT_W-1:0]       total_r;
  logic signed [SUM_W-1:0] gsum_r, rsum_r;
  logic [SUM_W-1:0]       gq_r, rq_r;
  logic [TOT_W:0]         grem_r, rrem_r;
  logic                   gneg_r;
  logic [DCNT_W-1:0]      dcnt_r;

  logic [NUM_STREAMS-1:0] sbit, await_after, live_after;
  logic                   item_ok;
  logic [NODE_W-1:0]      cf, ct;
  logic                   cur_live, cur_less, cur_eq;
  logic signed [CNT_W+GAP_W:0] gprod;
  logic signed [CNT_W+RNG_W:0] rprod;
  logic [TOT_W:0]         gtry, rtry;
  logic [GAP_W-1:0]       mg;
  logic [RNG_W-1:0]       mr;
  logic [SUM_W-1:0]       gmag;

  assign sbit = NUM_STREAMS'(1) << in_stream;
  assign item_ok = !finished_r && ((await_r & sbit) != '0);
  assign await_after = await_r & ~sbit;
  assign live_after = in_ended ? (live_r & ~sbit) : live_r;

  assign cf = head_from_r[idx_r];
  assign ct = head_to_r[idx_r];
  assign cur_live = live_r[idx_r];
  assign cur_less = (cf < min_from_r) || (cf == min_from_r && ct < min_to_r);
  assign cur_eq = (cf == min_from_r) && (ct == min_to_r);
  assign gprod = $signed({1'b0, head_cnt_r[idx_r]}) * $signed(head_gap_r[idx_r]);
  assign rprod = $signed({1'b0, head_cnt_r[idx_r]}) * $signed({1'b0, head_rng_r[idx_r]});

  // one quotient bit a cycle for both means
  assign gtry = {grem_r[TOT_W-1:0], gq_r[SUM_W-1]};
  assign rtry = {rrem_r[TOT_W-1:0], rq_r[SUM_W-1]};
  assign gmag = gsum_r[SUM_W-1] ? SUM_W'(-gsum_r) : SUM_W'(gsum_r);
  assign mg = gneg_r ? GAP_W'(-gq_r[GAP_W-1:0]) : gq_r[GAP_W-1:0];
  assign mr = rq_r[RNG_W-1:0];

  always_comb begin
    sts.trigger = item_ok && (await_after == '0);
    sts.none_live = (live_after == '0);
    sts.idx_last = (idx_r == STREAM_W'(NUM_STREAMS - 1));
    sts.pass = (total_r != '0) && (total_r >= min_count);
    sts.div_done = (dcnt_r == DCNT_W'(1));
    sts.emit_ok = $signed({mg[GAP_W-1], mg}) >=
                  -$signed({2'b00, mr[RNG_W-1:1]});
    sts.cur_consumed = cons_r[idx_r];
    sts.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && item_ok && !in_ended) begin
      head_from_r[in_stream] <= in_from;
      head_to_r[in_stream] <= in_to;
      head_cnt_r[in_stream] <= in_count;
      head_gap_r[in_stream] <= in_gap;
      head_rng_r[in_stream] <= in_range;
    end
    if (cmd.min_step && cur_live && (!have_r || idx_r == '0 || cur_less)) begin
      min_from_r <= cf;
      min_to_r <= ct;
    end
    if (cmd.acc_step) begin
      if (cur_live && cur_eq) begin
        total_r <= (idx_r == '0 ? '0 : total_r) + TOT_W'(head_cnt_r[idx_r]);
        gsum_r <= (idx_r == '0 ? '0 : gsum_r) + SUM_W'(gprod);
        rsum_r <= (idx_r == '0 ? '0 : rsum_r) + SUM_W'(rprod);
      end else if (idx_r == '0) begin
        total_r <= '0;
        gsum_r <= '0;
        rsum_r <= '0;
      end
    end
    if (cmd.div_start) begin
      gq_r <= gmag;
      rq_r <= SUM_W'(rsum_r);
      grem_r <= '0;
      rrem_r <= '0;
      gneg_r <= gsum_r[SUM_W-1];
    end else if (cmd.div_step) begin
      if (gtry >= {1'b0, total_r}) begin
        grem_r <= gtry - {1'b0, total_r};
        gq_r <= {gq_r[SUM_W-2:0], 1'b1};
      end else begin
        grem_r <= gtry;
        gq_r <= {gq_r[SUM_W-2:0], 1'b0};
      end
      if (rtry >= {1'b0, total_r}) begin
        rrem_r <= rtry - {1'b0, total_r};
        rq_r <= {rq_r[SUM_W-2:0], 1'b1};
      end else begin
        rrem_r <= rtry;
        rq_r <= {rq_r[SUM_W-2:0], 1'b0};
      end
    end
    if (cmd.load_edge) begin
      out_kind <= KIND_EDGE;
      out_req <= '0;
      out_from <= min_from_r;
      out_to <= min_to_r;
      out_total <= total_r;
      out_gap <= mg;
      out_range <= mr;
      out_last <= 1'b0;
    end else if (cmd.load_req) begin
      out_kind <= KIND_REQ;
      out_req <= idx_r;
      out_from <= '0;
      out_to <= '0;
      out_total <= '0;
      out_gap <= '0;
      out_range <= '0;
      out_last <= ((cons_r >> idx_r) >> 1) == '0;
    end else if (cmd.load_done) begin
      out_kind <= KIND_DONE;
      out_req <= '0;
      out_from <= '0;
      out_to <= '0;
      out_total <= '0;
      out_gap <= '0;
      out_range <= '0;
      out_last <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '1;
      await_r <= '1;
      cons_r <= '0;
      finished_r <= 1'b0;
      idx_r <= '0;
      have_r <= 1'b0;
      dcnt_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept && item_ok) begin
        await_r <= await_after;
        live_r <= live_after;
      end
      if (cmd.idx_step) idx_r <= sts.idx_last ? '0 : idx_r + STREAM_W'(1);
      if (cmd.min_step) begin
        if (idx_r == '0) have_r <= cur_live;
        else if (cur_live) have_r <= 1'b1;
      end
      // first scan slot clears the stale mask from the previous round
      if (cmd.acc_step) begin
        cons_r <= (idx_r == '0 ? '0 : cons_r) |
                  (NUM_STREAMS'(cur_live && cur_eq) << idx_r);
      end
      if (cmd.set_await) await_r <= cons_r;
      if (cmd.div_start) dcnt_r <= DCNT_W'(DIV_STEPS);
      else if (cmd.div_step && dcnt_r != '0) dcnt_r <= dcnt_r - DCNT_W'(1);
      if (cmd.load_done) finished_r <= 1'b1;
      if (cmd.load_edge || cmd.load_req || cmd.load_done) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule

[rtl/sorted_link_merge_reducer.sv]
// top level: k-way merge of sorted link streams reduced by key
// sequence: the beat that completes a round starts a min scan and an accumulate scan over all
//   streams and a check; a divide and an edge step follow when the group passes the threshold
// input: a round holds off the input until its refill pass is through, and output stalls hold
//   it off longer; while no round is in progress the input stays ready
// reset: synchronous active-low rst_n; all streams live and awaited, done flag clear
`timescale 1ns / 1ps
module sorted_link_merge_reducer import slmr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [143:0]  in_tdata,  // from_node, to_node, link_count, link_gap, gap_range, pad
  input  logic [4:0]    in_tuser,  // stream, ended
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [151:0]  out_tdata, // req_stream, edge_from, edge_to, total_count, mean_gap,
                                   // mean_range, pad
  output logic [1:0]    out_tuser, // kind
  output logic          out_tlast,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);
  slmr_cmd_t cmd;
  slmr_sts_t sts;
  logic [TOT_W-1:0] min_count_r;
  logic [STREAM_W-1:0] o_req;
  logic [NODE_W-1:0] o_from, o_to;
  logic [TOT_W-1:0] o_total;
  logic [GAP_W-1:0] o_gap;
  logic [RNG_W-1:0] o_range;

  // config register: min_link_count at byte address 0
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_MIN_LINK_COUNT) ? {12'd0, min_count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_count_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == REG_MIN_LINK_COUNT) begin
      min_count_r <= cfg_pwdata[TOT_W-1:0];
    end
  end

  slmr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  slmr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_stream (in_tuser[3:0]),
    .in_ended  (in_tuser[4]),
    .in_from   (in_tdata[31:0]),
    .in_to     (in_tdata[63:32]),
    .in_count  (in_tdata[79:64]),
    .in_gap    (in_tdata[111:80]),
    .in_range  (in_tdata[142:112]),
    .min_count (min_count_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_last  (out_tlast),
    .out_req   (o_req),
    .out_from  (o_from),
    .out_to    (o_to),
    .out_total (o_total),
    .out_gap   (o_gap),
    .out_range (o_range)
  );

  // pack result beat, lowest field first
  assign out_tdata = {1'b0, o_range, o_gap, o_total, o_to, o_from, o_req};

`ifndef SYNTHESIS
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_DONE |-> out_tlast)
    else $error("done beat without last");
  a_edge_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_EDGE |-> !out_tlast)
    else $error("edge beat marked last");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(cmd.div_step || cmd.acc_step || cmd.min_step))
    else $error("input ready during group processing");
`endif
endmodule

[tb/sorted_link_merge_reducer_test.sv]
// testbench for the sorted link merge reducer: random merge rounds checked against a predictor
`timescale 1ns / 1ps
module sorted_link_merge_reducer_test;
  import slmr_pkg::*;

  // one beat on the result channel, unpacked
  typedef struct {
    logic [1:0]        kind;
    logic [3:0]        req_stream;
    logic [31:0]       edge_from;
    logic [31:0]       edge_to;
    logic [19:0]       total_count;
    logic [31:0]       mean_gap;
    logic [30:0]       mean_range;
    logic              last;
  } link_result_t;

  // merge predictor plus the queue of results still owed by the block
  class link_scoreboard;
    logic [31:0]        head_from [NUM_STREAMS];
    logic [31:0]        head_to [NUM_STREAMS];
    logic [15:0]        head_cnt [NUM_STREAMS];
    logic signed [31:0] head_gap [NUM_STREAMS];
    logic [30:0]        head_rng [NUM_STREAMS];
    logic [15:0]        live_mask;
    logic [15:0]        await_mask;
    bit                 all_done;
    logic [19:0]        min_count;
    link_result_t       owed [$];
    int                 errors;

    function new();
      live_mask = '1;
      await_mask = '1;
      all_done = 0;
      min_count = '0;
      errors = 0;
    endfunction

    function void push_result(logic [1:0] kind, logic [3:0] req, logic [31:0] ef,
                              logic [31:0] et, logic [19:0] tc, logic [31:0] mg,
                              logic [30:0] mr);
      link_result_t r;
      r.kind = kind;
      r.req_stream = req;
      r.edge_from = ef;
      r.edge_to = et;
      r.total_count = tc;
      r.mean_gap = mg;
      r.mean_range = mr;
      r.last = 0;
      owed.insert(owed.size(), r);
    endfunction

    // called for every accepted input beat, in acceptance order
    function void note_item(logic [3:0] s, logic ended, logic [31:0] f, logic [31:0] t,
                            logic [15:0] c, logic [31:0] g, logic [30:0] r);
      logic [31:0] kf, kt;
      logic [15:0] used;
      longint      total, gsum, rsum, mg, mr;
      bit          found;
      int          n0;
      if (all_done || !await_mask[s]) return;  // ignored beat
      await_mask[s] = 0;
      if (ended) begin
        live_mask[s] = 0;
      end else begin
        head_from[s] = f;
        head_to[s] = t;
        head_cnt[s] = c;
        head_gap[s] = g;
        head_rng[s] = r;
      end
      if (await_mask != 0) return;
      n0 = owed.size();
      if (live_mask == 0) begin
        all_done = 1;
        push_result(KIND_DONE, 0, 0, 0, 0, 0, 0);
      end else begin
        found = 0;
        kf = 0;
        kt = 0;
        for (int i = 0; i < NUM_STREAMS; i++)
          if (live_mask[i] && (!found || head_from[i] < kf ||
              (head_from[i] == kf && head_to[i] < kt))) begin
            kf = head_from[i];
            kt = head_to[i];
            found = 1;
          end
        used = 0;
        total = 0;
        gsum = 0;
        rsum = 0;
        for (int i = 0; i < NUM_STREAMS; i++)
          if (live_mask[i] && head_from[i] == kf && head_to[i] == kt) begin
            used[i] = 1;
            total += head_cnt[i];
            gsum += longint'(head_cnt[i]) * longint'(head_gap[i]);
            rsum += longint'(head_cnt[i]) * longint'(head_rng[i]);
          end
        // zero total never produces an edge
        if (total != 0 && total >= min_count) begin
          mg = gsum / total;
          mr = rsum / total;
          if (mg >= -(mr / 2))
            push_result(KIND_EDGE, 0, kf, kt, 20'(total), 32'(mg), 31'(mr));
        end
        for (int i = 0; i < NUM_STREAMS; i++)
          if (used[i]) push_result(KIND_REQ, 4'(i), 0, 0, 0, 0, 0);
        await_mask = used;
      end
      if (owed.size() > n0) owed[owed.size() - 1].last = 1;
    endfunction

    function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(link_result_t got);
      link_result_t e;
      if (owed.size() == 0) begin
        $error("unexpected result beat, kind %0d", got.kind);
        errors++;
        return;
      end
      e = owed.pop_front();
      cmp("kind", e.kind, got.kind);
      cmp("req_stream", e.req_stream, got.req_stream);
      cmp("edge_from", e.edge_from, got.edge_from);
      cmp("edge_to", e.edge_to, got.edge_to);
      cmp("total_count", e.total_count, got.total_count);
      cmp("mean_gap", e.mean_gap, got.mean_gap);
      cmp("mean_range", e.mean_range, got.mean_range);
      cmp("last", e.last, got.last);
    endfunction
  endclass

  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 200;  // well past scan + accumulate + divide latency

  logic          clk = 0;
  logic          rst_n = 0;
  logic          in_tvalid = 0;
  logic          in_tready;
  logic [143:0]  in_tdata = '0;  // from_node, to_node, link_count, link_gap, gap_range, pad
  logic [4:0]    in_tuser = '0;  // stream, ended
  logic          out_tvalid;
  logic          out_tready = 0;
  logic [151:0]  out_tdata;      // req_stream, edge_from, edge_to, total_count, mean_gap,
                                 // mean_range, pad
  logic [1:0]    out_tuser;      // kind
  logic          out_tlast;
  logic          cfg_psel = 0;
  logic          cfg_penable = 0;
  logic          cfg_pwrite = 0;
  logic [2:0]    cfg_paddr = '0;
  logic [31:0]   cfg_pwdata = '0;
  logic [31:0]   cfg_prdata;
  logic          cfg_pready;

  link_scoreboard merge_sb = new();
  int  cycle_count = 0;
  int  beats_sent = 0;
  bit  quiet = 0;        // no idling in the closing part of the run
  bit  hold_request = 0; // asks the receiver for one long hold-off
  int  left_in_stream [NUM_STREAMS];

  sorted_link_merge_reducer u_top (.*);

  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    link_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.req_stream = out_tdata[3:0];
      got.edge_from = out_tdata[35:4];
      got.edge_to = out_tdata[67:36];
      got.total_count = out_tdata[87:68];
      got.mean_gap = out_tdata[119:88];
      got.mean_range = out_tdata[150:120];
      got.kind = out_tuser;
      got.last = out_tlast;
      merge_sb.check_result(got);
    end
  end

  // receiver: ready in random bursts with random stalls, one long hold-off on request
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 0;
        out_tready = 0;
        for (int i = 0; i < 600; i++) @(negedge clk);  // block backs up into its input
      end
      out_tready = 1;
      n = $urandom_range(1, 16);
      for (int i = 1; i < n; i++) @(negedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        @(negedge clk);
        out_tready = 0;
        n = $urandom_range(1, 16);
        for (int i = 1; i < n; i++) @(negedge clk);
      end
    end
  end

  // offer one beat from a falling edge and hold it until accepted; valid stays high after
  task automatic send_link(logic [3:0] s, logic ended, logic [31:0] f, logic [31:0] t,
                           logic [15:0] c, logic [31:0] g, logic [30:0] r);
    in_tdata = {1'b0, r, g, c, t, f};
    in_tuser = {ended, s};
    in_tvalid = 1;
    do @(posedge clk); while (!in_tready);
    merge_sb.note_item(s, ended, f, t, c, g, r);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int n;
    in_tvalid = 0;
    n = $urandom_range(1, 16);
    repeat (n) @(negedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_min_count(logic [19:0] value);
    in_tvalid = 0;
    while (merge_sb.owed.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_psel = 1;
    cfg_pwrite = 1;
    cfg_paddr = 3'(4 * REG_MIN_LINK_COUNT);
    cfg_pwdata = 32'(value);
    @(negedge clk);
    cfg_penable = 1;
    @(negedge clk);
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    merge_sb.min_count = value;
  endtask

  // random link for stream s: small key space so groups collide, now and then wide values
  task automatic send_random_link(logic [3:0] s);
    logic [31:0] f, t, g;
    logic [15:0] c;
    logic [30:0] r;
    f = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 5);
    t = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3);
    c = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    g = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom_range(0, 2000)) - 1000);
    r = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 3000));
    send_link(s, 0, f, t, c, g, r);
  endtask

  initial begin
    logic [19:0] phase_values [5];
    int          s, phase;
    logic [15:0] pend;
    phase_values = '{20'hFFFFF, 20'd5, 20'd0, 20'd1, 20'd0};
    for (int i = 0; i < NUM_STREAMS; i++) left_in_stream[i] = $urandom_range(10, 22);
    repeat (12) @(negedge clk);
    rst_n = 1;
    write_min_count(20'd0);

    // directed first round: extremes share one key, the largest key, an ended stream
    send_link(0, 0, 0, 0, 16'hFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF);
    send_link(1, 0, 0, 0, 16'hFFFF, 32'h80000000, 31'h7FFFFFFF);
    send_link(2, 0, 0, 0, 16'hFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF);
    send_link(3, 0, 0, 0, 16'd0, 32'hFFFFFFFF, 31'd0);
    send_link(4, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'd1, 32'd0, 31'd0);
    send_link(5, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF);
    for (int i = 6; i < NUM_STREAMS; i++) send_random_link(4'(i) + 4'd0);
    // refills: a lone link whose gap falls below minus half its range, then zero counts
    send_link(0, 0, 32'd1, 32'd1, 16'd5, -32'sd1000, 31'd10);
    for (int i = 1; i < 4; i++) send_link(4'(i), 0, 32'd2, 32'd2, 16'd0, 32'd7, 31'd9);
    // stream 15 is not awaited here: ignored
    send_link(15, 0, 32'd0, 32'd0, 16'd1, 32'd0, 31'd0);
    // zero total group: refills but no edge
    send_link(0, 0, 32'd2, 32'd2, 16'd0, 32'd3, 31'd4);

    // random merge rounds until every stream has ended
    phase = 0;
    while (!merge_sb.all_done) begin
      if (beats_sent >= 60 * (phase + 1) && phase < 5) begin
        write_min_count(phase == 2 ? 20'($urandom) : phase_values[phase]);
        phase++;
      end
      if (beats_sent == 120) hold_request = 1;
      if (beats_sent >= 260) quiet = 1;
      if (!quiet && $urandom_range(0, 3) == 0) sender_gap();
      pend = merge_sb.await_mask;
      if ($urandom_range(0, 9) == 0) begin
        // noise: a beat for any stream, usually not awaited and dropped
        send_random_link(4'($urandom));
      end else begin
        do s = $urandom_range(0, NUM_STREAMS - 1); while (!pend[s]);
        if (left_in_stream[s] == 0)
          send_link(4'(s), 1, $urandom, $urandom, 16'($urandom), $urandom, 31'($urandom));
        else begin
          left_in_stream[s]--;
          send_random_link(4'(s));
        end
      end
    end
    // beats after done are ignored
    send_link(4'($urandom), 0, 32'd1, 32'd1, 16'd1, 32'd0, 31'd0);
    send_link(4'($urandom), 1, 32'd1, 32'd1, 16'd1, 32'd0, 31'd0);
    in_tvalid = 0;

    while (merge_sb.owed.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (merge_sb.errors == 0 && merge_sb.owed.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
